FILE: sv/rvex_pkg.sv
// rvex_pkg: shared types, opcodes and memory sizing for the rv32i execute unit
package rvex_pkg;

	// data memory sizing (byte count, four byte lanes)
	localparam int DMEM_BYTES = 4096;
	localparam int DMEM_AW    = $clog2(DMEM_BYTES);
	localparam int DMEM_ROWS  = DMEM_BYTES / 4;
	localparam int ROW_W      = DMEM_AW - 2;

	// major opcodes
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;

	// funct7 patterns
	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	// alu funct3
	localparam logic [2:0] F3_ADD  = 3'b000;
	localparam logic [2:0] F3_SLL  = 3'b001;
	localparam logic [2:0] F3_SLT  = 3'b010;
	localparam logic [2:0] F3_SLTU = 3'b011;
	localparam logic [2:0] F3_XOR  = 3'b100;
	localparam logic [2:0] F3_SR   = 3'b101;
	localparam logic [2:0] F3_OR   = 3'b110;
	localparam logic [2:0] F3_AND  = 3'b111;

	// branch funct3
	localparam logic [2:0] BR_EQ  = 3'b000;
	localparam logic [2:0] BR_NE  = 3'b001;
	localparam logic [2:0] BR_LT  = 3'b100;
	localparam logic [2:0] BR_GE  = 3'b101;
	localparam logic [2:0] BR_LTU = 3'b110;
	localparam logic [2:0] BR_GEU = 3'b111;

	// load / store funct3
	localparam logic [2:0] LS_B  = 3'b000;
	localparam logic [2:0] LS_H  = 3'b001;
	localparam logic [2:0] LS_W  = 3'b010;
	localparam logic [2:0] LS_BU = 3'b100;
	localparam logic [2:0] LS_HU = 3'b101;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_MISALIGN    = 3'd1,
		ST_LOAD_FAULT  = 3'd2,
		ST_STORE_FAULT = 3'd3,
		ST_UNSUPPORTED = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        dest_written;
		logic        branch_taken;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic                  load;
		logic                  store;
		logic [3:0]            lane_en;
		logic [3:0][ROW_W-1:0] row;
		logic [3:0][7:0]       wdata;
	} mem_req_t;

endpackage

FILE: sv/rvex_ram.sv
// rvex_ram: generic single-write, single-read ram with registered read data
module rvex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/rvex_exec.sv
// rvex_exec: decode and execute of one instruction, plus data memory request
module rvex_exec (
	input  logic [31:0]       instr,
	input  logic [31:0]       pc,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [3:0][7:0]   ld_data,
	output rvex_pkg::result_t  res,
	output rvex_pkg::mem_req_t mreq
);
	import rvex_pkg::*;

	function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt,
			logic [31:0] x, logic [31:0] y);
		logic [4:0]  sh;
		logic [31:0] r;
		sh = y[4:0];
		case (f3)
			F3_ADD:  r = alt ? x - y : x + y;
			F3_SLL:  r = x << sh;
			F3_SLT:  r = {31'b0, $signed(x) < $signed(y)};
			F3_SLTU: r = {31'b0, x < y};
			F3_XOR:  r = x ^ y;
			F3_SR:   r = alt ? $unsigned($signed(x) >>> sh) : x >> sh;
			F3_OR:   r = x | y;
			default: r = x & y;
		endcase
		return r;
	endfunction

	logic [6:0]  opc, f7;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	logic [31:0] addr, jalr_tgt, pc_plus4;
	logic [2:0]  size;
	logic [32:0] end_addr;
	logic        in_range;
	logic [3:0][1:0]         lane_off;
	logic [3:0][DMEM_AW-1:0] lane_baddr;
	logic [3:0][7:0]         ld_byte;
	logic [31:0] ld_raw, ld_val;

	// field split and immediates
	assign opc   = instr[6:0];
	assign rd    = instr[11:7];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign pc_plus4 = pc + 32'd4;
	assign jalr_tgt = (a + imm_i) & ~32'd1;

	// memory address and range check
	assign addr     = a + ((opc == OPC_STORE) ? imm_s : imm_i);
	assign size     = 3'b001 << f3[1:0];
	assign end_addr = {1'b0, addr} + {30'b0, size};
	assign in_range = end_addr <= 33'(DMEM_BYTES);

	// per lane byte offset, row and load byte gather
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lane_off[k]   = 2'(k) - addr[1:0];
			lane_baddr[k] = addr[DMEM_AW-1:0] + DMEM_AW'(lane_off[k]);
			ld_byte[k]    = ld_data[2'(addr[1:0] + 2'(k))];
		end
	end

	assign ld_raw = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};

	// load value formatting
	always_comb begin
		case (f3)
			LS_B:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
			LS_H:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
			LS_W:    ld_val = ld_raw;
			LS_BU:   ld_val = {24'b0, ld_raw[7:0]};
			default: ld_val = {16'b0, ld_raw[15:0]};
		endcase
	end

	// execute
	always_comb begin
		logic        wr, taken, cond, is_load, is_store;
		logic [31:0] npc, val, tgt;
		status_t     st;
		wr       = 1'b0;
		taken    = 1'b0;
		cond     = 1'b0;
		is_load  = 1'b0;
		is_store = 1'b0;
		npc      = pc_plus4;
		val      = '0;
		tgt      = '0;
		st       = ST_OK;
		case (opc)
			OPC_LUI: begin
				val = {instr[31:12], 12'b0};
				wr  = 1'b1;
			end
			OPC_AUIPC: begin
				val = pc + {instr[31:12], 12'b0};
				wr  = 1'b1;
			end
			OPC_JAL: begin
				tgt = pc + imm_j;
				if (tgt[1:0] != 2'b00) begin
					st = ST_MISALIGN;
				end else begin
					val = pc_plus4; wr = 1'b1; npc = tgt; taken = 1'b1;
				end
			end
			OPC_JALR: begin
				if (f3 != 3'b000) begin
					st = ST_UNSUPPORTED;
				end else if (jalr_tgt[1:0] != 2'b00) begin
					st = ST_MISALIGN;
				end else begin
					val = pc_plus4; wr = 1'b1; npc = jalr_tgt; taken = 1'b1;
				end
			end
			OPC_BRANCH: begin
				case (f3)
					BR_EQ:   cond = a == b;
					BR_NE:   cond = a != b;
					BR_LT:   cond = $signed(a) < $signed(b);
					BR_GE:   cond = !($signed(a) < $signed(b));
					BR_LTU:  cond = a < b;
					BR_GEU:  cond = a >= b;
					default: st = ST_UNSUPPORTED;
				endcase
				if (st == ST_OK && cond) begin
					tgt = pc + imm_b;
					if (tgt[1:0] != 2'b00) begin
						st = ST_MISALIGN;
					end else begin
						npc = tgt; taken = 1'b1;
					end
				end
			end
			OPC_LOAD: begin
				if (f3 inside {3'b011, 3'b110, 3'b111}) begin
					st = ST_UNSUPPORTED;
				end else if (!in_range) begin
					st = ST_LOAD_FAULT;
				end else begin
					is_load = 1'b1; val = ld_val; wr = 1'b1;
				end
			end
			OPC_STORE: begin
				if (f3 > LS_W) begin
					st = ST_UNSUPPORTED;
				end else if (!in_range) begin
					st = ST_STORE_FAULT;
				end else begin
					is_store = 1'b1;
				end
			end
			OPC_OPIMM: begin
				if (f3 == F3_SLL && f7 != F7_BASE) begin
					st = ST_UNSUPPORTED;
				end else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) begin
					st = ST_UNSUPPORTED;
				end else begin
					val = alu_op(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
					wr  = 1'b1;
				end
			end
			OPC_OP: begin
				if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))) begin
					st = ST_UNSUPPORTED;
				end else begin
					val = alu_op(f3, f7 == F7_ALT, a, b);
					wr  = 1'b1;
				end
			end
			default: st = ST_UNSUPPORTED;
		endcase

		// a fault leaves all state alone
		if (st != ST_OK) begin
			npc = pc; taken = 1'b0; wr = 1'b0;
		end
		res.next_pc      = npc;
		res.branch_taken = taken;
		res.status       = st;
		if (wr && rd != 5'd0) begin
			res.dest_written = 1'b1;
			res.dest_index   = rd;
			res.dest_value   = val;
		end else begin
			res.dest_written = 1'b0;
			res.dest_index   = '0;
			res.dest_value   = '0;
		end

		mreq.load  = is_load;
		mreq.store = is_store;
		for (int k = 0; k < 4; k++) begin
			mreq.row[k]     = lane_baddr[k][DMEM_AW-1:2];
			mreq.lane_en[k] = {1'b0, lane_off[k]} < size;
			mreq.wdata[k]   = 8'(b >> {lane_off[k], 3'b000});
		end
	end

endmodule

FILE: sv/rv32i_execute_unit.sv
// rv32i_execute_unit: top level with input stage, register file, data memory and output register
// One instruction word is taken per cycle unless a load, output back-pressure or the
// clearing pass stalls; the word is registered into the execute stage and its result
// into the output register. Data memory (four byte-lane rams) has a registered read, so
// a load retires only once its read data returns, holding the next instruction.
// The register file is held in rams with registered read plus a one-entry bypass of the
// latest write. After reset the data memory is cleared, one row of all four lanes per
// cycle with in_ready low. Writing the start address loads the program counter directly.
module rv32i_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        dest_written,
	output logic        branch_taken,
	output logic [2:0]  status
);
	import rvex_pkg::*;

	logic             in_xfer, commit, ld_issue;
	logic             valid_s1, ld_phase_s1;
	logic [31:0]      instr_s1;
	logic [31:0]      pc_q;
	logic [31:0]      rf_valid_q;
	logic             fwd_valid_q;
	logic [4:0]       fwd_idx_q;
	logic [31:0]      fwd_data_q;
	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             out_valid_q;
	result_t          res_q, res;
	mem_req_t         mreq;
	logic [31:0]      rd1, rd2, op_a, op_b;
	logic [4:0]       rs1_s1, rs2_s1;
	logic [3:0][7:0]  ld_data;

	assign rs1_s1 = instr_s1[19:15];
	assign rs2_s1 = instr_s1[24:20];

	// handshake and stage control
	assign commit   = valid_s1 && (!mreq.load || ld_phase_s1) && (!out_valid_q || out_ready);
	assign ld_issue = valid_s1 && mreq.load && !ld_phase_s1;
	assign in_ready = !clr_busy_q && (!valid_s1 || commit);
	assign in_xfer  = in_valid && in_ready;

	// register file, one copy per read port
	rvex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(commit && res.dest_written), .waddr(res.dest_index),
		.wdata(res.dest_value), .re(in_xfer), .raddr(instr_word[19:15]), .rdata(rd1)
	);
	rvex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(commit && res.dest_written), .waddr(res.dest_index),
		.wdata(res.dest_value), .re(in_xfer), .raddr(instr_word[24:20]), .rdata(rd2)
	);

	// operand select: x0, bypass of latest write, unwritten entry, ram
	always_comb begin
		if (rs1_s1 == 5'd0) begin
			op_a = '0;
		end else if (fwd_valid_q && fwd_idx_q == rs1_s1) begin
			op_a = fwd_data_q;
		end else if (rf_valid_q[rs1_s1]) begin
			op_a = rd1;
		end else begin
			op_a = '0;
		end
		if (rs2_s1 == 5'd0) begin
			op_b = '0;
		end else if (fwd_valid_q && fwd_idx_q == rs2_s1) begin
			op_b = fwd_data_q;
		end else if (rf_valid_q[rs2_s1]) begin
			op_b = rd2;
		end else begin
			op_b = '0;
		end
	end

	rvex_exec u_exec (
		.instr(instr_s1), .pc(pc_q), .a(op_a), .b(op_b), .ld_data(ld_data),
		.res(res), .mreq(mreq)
	);

	// data memory byte lanes, shared with the clearing pass
	for (genvar k = 0; k < 4; k++) begin : g_lane
		rvex_ram #(.WIDTH(8), .DEPTH(DMEM_ROWS)) u_dmem (
			.clk(clk),
			.we(clr_busy_q || (commit && mreq.store && mreq.lane_en[k])),
			.waddr(clr_busy_q ? clr_row_q : mreq.row[k]),
			.wdata(clr_busy_q ? 8'd0 : mreq.wdata[k]),
			.re(ld_issue),
			.raddr(mreq.row[k]),
			.rdata(ld_data[k])
		);
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ld_phase_s1 <= 1'b0;
			pc_q        <= '0;
			rf_valid_q  <= '0;
			fwd_valid_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// memory clearing pass
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == ROW_W'(DMEM_ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			// execute stage occupancy
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				ld_phase_s1 <= 1'b0;
			end else if (ld_issue) begin
				ld_phase_s1 <= 1'b1;
			end
			// retire
			if (commit) begin
				pc_q <= res.next_pc;
				if (res.dest_written) begin
					rf_valid_q[res.dest_index] <= 1'b1;
					fwd_valid_q                <= 1'b1;
				end
			end
			if (cfg_wr_en) begin
				pc_q <= cfg_wr_data;
			end
			// output register transfer
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			instr_s1 <= instr_word;
		end
		if (commit) begin
			res_q <= res;
			if (res.dest_written) begin
				fwd_idx_q  <= res.dest_index;
				fwd_data_q <= res.dest_value;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = res_q.next_pc;
	assign dest_index   = res_q.dest_index;
	assign dest_value   = res_q.dest_value;
	assign dest_written = res_q.dest_written;
	assign branch_taken = res_q.branch_taken;
	assign status       = res_q.status;

	// checks
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.dest_written && res_q.dest_index == 5'd0))
		else $error("x0 reported as written");
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != ST_OK) |-> (!res_q.dest_written && !res_q.branch_taken))
		else $error("faulting instruction had an effect");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("instruction accepted during memory clear");
	a_load_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ld_phase_s1 |-> valid_s1)
		else $error("load data phase without an instruction");
	a_store_not_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !clr_busy_q)
		else $error("retire during memory clear");

endmodule

FILE: dv/rv32i_execute_unit_tb.sv
// testbench for rv32i_execute_unit: instruction stream against an in-bench execute model
module testbench;
	import rvex_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] OPC_FENCE = 7'h0F;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASES = 6;
	localparam int         RAND_PER_PHASE = 67;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instr_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_pc;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic        dest_written;
	logic        branch_taken;
	logic [2:0]  status;

	rv32i_execute_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instr_word(instr_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_pc(next_pc),
		.dest_index(dest_index),
		.dest_value(dest_value),
		.dest_written(dest_written),
		.branch_taken(branch_taken),
		.status(status)
	);

	// architectural state of the model
	logic [31:0] arch_regs [32];
	logic [7:0]  arch_mem [DMEM_BYTES];
	logic [31:0] arch_pc;

	logic [31:0] instr_q [$];
	result_t     retire_q [$];
	int          send_idle;
	int          recv_idle;
	bit          in_done;
	int          mismatches;
	int          cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// instruction encoders
	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
		return {imm, rd, opc};
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_OP};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	// integer alu shared by register and immediate forms
	function automatic logic [31:0] alu_result(logic [2:0] f3, bit alt, logic [31:0] x,
			logic [31:0] y);
		logic [4:0] sh;
		sh = y[4:0];
		case (f3)
			F3_ADD:  return alt ? x - y : x + y;
			F3_SLL:  return x << sh;
			F3_SLT:  return {31'b0, $signed(x) < $signed(y)};
			F3_SLTU: return {31'b0, x < y};
			F3_XOR:  return x ^ y;
			F3_SR:   return alt ? $unsigned($signed(x) >>> sh) : x >> sh;
			F3_OR:   return x | y;
			default: return x & y;
		endcase
	endfunction

	// execute one instruction on the model state and return its retirement record
	task automatic retire_instr(input logic [31:0] w, output result_t r);
		logic [6:0]  opc;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm_i;
		logic [31:0] imm_s;
		logic [31:0] imm_b;
		logic [31:0] imm_j;
		logic [31:0] npc;
		logic [31:0] val;
		logic [31:0] tgt;
		logic [31:0] addr;
		int          size;
		status_t     st;
		bit          wr;
		bit          taken;
		bit          cond;
		opc = w[6:0];
		rd = w[11:7];
		f3 = w[14:12];
		f7 = w[31:25];
		a = arch_regs[w[19:15]];
		b = arch_regs[w[24:20]];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		npc = arch_pc + 32'd4;
		val = '0;
		st = ST_OK;
		wr = 1'b0;
		taken = 1'b0;
		cond = 1'b0;
		case (opc)
			OPC_LUI: begin
				val = {w[31:12], 12'b0};
				wr = 1'b1;
			end
			OPC_AUIPC: begin
				val = arch_pc + {w[31:12], 12'b0};
				wr = 1'b1;
			end
			OPC_JAL: begin
				tgt = arch_pc + imm_j;
				if (tgt[1:0] != 2'b00) st = ST_MISALIGN;
				else begin
					val = arch_pc + 32'd4;
					wr = 1'b1;
					npc = tgt;
					taken = 1'b1;
				end
			end
			OPC_JALR: begin
				tgt = (a + imm_i) & ~32'd1;
				if (f3 != 3'b000) st = ST_UNSUPPORTED;
				else if (tgt[1:0] != 2'b00) st = ST_MISALIGN;
				else begin
					val = arch_pc + 32'd4;
					wr = 1'b1;
					npc = tgt;
					taken = 1'b1;
				end
			end
			OPC_BRANCH: begin
				case (f3)
					BR_EQ:  cond = a == b;
					BR_NE:  cond = a != b;
					BR_LT:  cond = $signed(a) < $signed(b);
					BR_GE:  cond = $signed(a) >= $signed(b);
					BR_LTU: cond = a < b;
					BR_GEU: cond = a >= b;
					default: st = ST_UNSUPPORTED;
				endcase
				if (st == ST_OK && cond) begin
					tgt = arch_pc + imm_b;
					if (tgt[1:0] != 2'b00) st = ST_MISALIGN;
					else begin
						npc = tgt;
						taken = 1'b1;
					end
				end
			end
			OPC_LOAD: begin
				if (!(f3 inside {LS_B, LS_H, LS_W, LS_BU, LS_HU})) st = ST_UNSUPPORTED;
				else begin
					size = 1 << f3[1:0];
					addr = a + imm_i;
					if (64'(addr) + 64'(size) > 64'(DMEM_BYTES)) st = ST_LOAD_FAULT;
					else begin
						for (int i = 0; i < size; i++)
							val[8*i +: 8] = arch_mem[addr + i];
						if (f3 == LS_B) val = {{24{val[7]}}, val[7:0]};
						if (f3 == LS_H) val = {{16{val[15]}}, val[15:0]};
						wr = 1'b1;
					end
				end
			end
			OPC_STORE: begin
				if (f3 > LS_W) st = ST_UNSUPPORTED;
				else begin
					size = 1 << f3;
					addr = a + imm_s;
					if (64'(addr) + 64'(size) > 64'(DMEM_BYTES)) st = ST_STORE_FAULT;
					else begin
						for (int i = 0; i < size; i++)
							arch_mem[addr + i] = b[8*i +: 8];
					end
				end
			end
			OPC_OPIMM: begin
				if (f3 == F3_SLL && f7 != F7_BASE) st = ST_UNSUPPORTED;
				else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) st = ST_UNSUPPORTED;
				else begin
					val = alu_result(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
					wr = 1'b1;
				end
			end
			OPC_OP: begin
				if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))))
					st = ST_UNSUPPORTED;
				else begin
					val = alu_result(f3, f7 == F7_ALT, a, b);
					wr = 1'b1;
				end
			end
			default: st = ST_UNSUPPORTED;
		endcase
		// a fault retires nothing and leaves the pc in place
		if (st != ST_OK) begin
			npc = arch_pc;
			taken = 1'b0;
			wr = 1'b0;
		end
		if (wr && rd != 5'd0) arch_regs[rd] = val;
		else begin
			wr = 1'b0;
			val = '0;
			rd = '0;
		end
		arch_pc = npc;
		r.next_pc = npc;
		r.dest_index = rd;
		r.dest_value = val;
		r.dest_written = wr;
		r.branch_taken = taken;
		r.status = st;
	endtask

	// random instruction, mostly well formed with random operands
	function automatic logic [31:0] rand_instr();
		int          k;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [11:0] imm;
		logic [12:0] bimm;
		logic [20:0] jimm;
		k = $urandom_range(99);
		rd = 5'($urandom_range(31));
		rs1 = 5'($urandom_range(31));
		rs2 = 5'($urandom_range(31));
		f3 = 3'($urandom_range(7));
		imm = 12'($urandom);
		if (k < 8) return $urandom;
		if (k < 14) return enc_u(20'($urandom), rd, $urandom_range(1) ? OPC_LUI : OPC_AUIPC);
		if (k < 27) begin
			// small base addresses keep later loads and stores in range
			if ($urandom_range(2) == 0)
				return enc_i(12'($urandom_range(2047)), 5'd0, F3_ADD, rd, OPC_OPIMM);
			if ($urandom_range(9) != 0) begin
				if (f3 == F3_SLL) imm[11:5] = F7_BASE;
				if (f3 == F3_SR) imm[11:5] = $urandom_range(1) ? F7_ALT : F7_BASE;
			end
			return enc_i(imm, rs1, f3, rd, OPC_OPIMM);
		end
		if (k < 40) begin
			f7 = (f3 inside {F3_ADD, F3_SR} && $urandom_range(1)) ? F7_ALT : F7_BASE;
			if ($urandom_range(9) == 0) f7 = 7'($urandom);
			return enc_r(f7, rs2, rs1, f3, rd);
		end
		if (k < 68) begin
			if ($urandom_range(1)) begin
				rs1 = 5'd0;
				imm = ($urandom_range(3) == 0) ? 12'($urandom_range(2040, 2047))
					: 12'($urandom_range(2047));
			end
			if (k < 55) begin
				if ($urandom_range(9) != 0) begin
					case ($urandom_range(4))
						0: f3 = LS_B;
						1: f3 = LS_H;
						2: f3 = LS_W;
						3: f3 = LS_BU;
						default: f3 = LS_HU;
					endcase
				end
				return enc_i(imm, rs1, f3, rd, OPC_LOAD);
			end
			if ($urandom_range(9) != 0) f3 = 3'($urandom_range(2));
			return enc_s(imm, rs2, rs1, f3);
		end
		if (k < 82) begin
			bimm = 13'($urandom);
			if ($urandom_range(3) != 0) bimm[1] = 1'b0;
			if ($urandom_range(9) != 0 && f3 inside {3'b010, 3'b011}) f3 = BR_EQ;
			return enc_b(bimm, rs2, rs1, f3);
		end
		if (k < 90) begin
			jimm = 21'($urandom);
			if ($urandom_range(3) != 0) jimm[1] = 1'b0;
			return enc_j(jimm, rd);
		end
		if ($urandom_range(9) != 0) f3 = 3'b000;
		return enc_i(imm, rs1, f3, rd, OPC_JALR);
	endfunction

	// directed opening: field extremes, every operation, each corner case
	task automatic load_directed();
		// upper immediates and immediate alu
		instr_q.push_back(enc_u(20'h80000, 5'd1, OPC_LUI));
		instr_q.push_back(enc_u(20'hFFFFF, 5'd2, OPC_AUIPC));
		instr_q.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd3, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h005, 5'd0, F3_ADD, 5'd0, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h000, 5'd3, F3_SLT, 5'd5, OPC_OPIMM));
		instr_q.push_back(enc_i(12'hFFF, 5'd4, F3_SLTU, 5'd6, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h555, 5'd3, F3_XOR, 5'd7, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h800, 5'd4, F3_OR, 5'd8, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h0F0, 5'd3, F3_AND, 5'd9, OPC_OPIMM));
		instr_q.push_back(enc_i({F7_BASE, 5'd31}, 5'd3, F3_SLL, 5'd10, OPC_OPIMM));
		instr_q.push_back(enc_i({F7_BASE, 5'd31}, 5'd1, F3_SR, 5'd11, OPC_OPIMM));
		instr_q.push_back(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd12, OPC_OPIMM));
		instr_q.push_back(enc_i({7'h01, 5'd1}, 5'd1, F3_SLL, 5'd13, OPC_OPIMM));
		// register alu, both funct7 forms and a bad one
		for (int f = 0; f < 8; f++)
			instr_q.push_back(enc_r(F7_BASE, 5'd4, 5'd1, 3'(f), 5'(14 + f)));
		instr_q.push_back(enc_r(F7_ALT, 5'd4, 5'd0, F3_ADD, 5'd22));
		instr_q.push_back(enc_r(F7_ALT, 5'd4, 5'd1, F3_SR, 5'd23));
		instr_q.push_back(enc_r(7'h01, 5'd4, 5'd1, F3_ADD, 5'd24));
		instr_q.push_back(enc_i(12'h7FF, 5'd4, F3_ADD, 5'd25, OPC_OPIMM));
		// stores and loads: in range, misaligned inside, past the end, bad funct3
		instr_q.push_back(enc_s(12'h000, 5'd3, 5'd0, LS_W));
		instr_q.push_back(enc_s(12'h005, 5'd1, 5'd0, LS_H));
		instr_q.push_back(enc_s(12'h7FF, 5'd7, 5'd4, LS_B));
		instr_q.push_back(enc_s(12'h000, 5'd3, 5'd25, LS_W));
		instr_q.push_back(enc_s(12'h000, 5'd3, 5'd0, 3'b011));
		instr_q.push_back(enc_i(12'h000, 5'd0, LS_W, 5'd26, OPC_LOAD));
		instr_q.push_back(enc_i(12'h005, 5'd0, LS_H, 5'd27, OPC_LOAD));
		instr_q.push_back(enc_i(12'h005, 5'd0, LS_HU, 5'd28, OPC_LOAD));
		instr_q.push_back(enc_i(12'h006, 5'd0, LS_B, 5'd29, OPC_LOAD));
		instr_q.push_back(enc_i(12'h7FF, 5'd4, LS_BU, 5'd30, OPC_LOAD));
		instr_q.push_back(enc_i(12'h000, 5'd25, LS_W, 5'd31, OPC_LOAD));
		instr_q.push_back(enc_i(12'h000, 5'd0, 3'b011, 5'd31, OPC_LOAD));
		// branches: taken, not taken with misaligned target, taken misaligned, bad funct3
		instr_q.push_back(enc_b(13'd8, 5'd0, 5'd0, BR_EQ));
		instr_q.push_back(enc_b(13'd6, 5'd0, 5'd0, BR_NE));
		instr_q.push_back(enc_b(13'd2, 5'd0, 5'd3, BR_LT));
		instr_q.push_back(enc_b(13'h1FFC, 5'd3, 5'd0, BR_GE));
		instr_q.push_back(enc_b(13'd4, 5'd3, 5'd0, BR_LTU));
		instr_q.push_back(enc_b(13'd4, 5'd0, 5'd3, BR_GEU));
		instr_q.push_back(enc_b(13'd4, 5'd0, 5'd0, 3'b010));
		// jumps: misaligned, normal, jalr with low bit cleared, misaligned jalr, bad jalr funct3
		instr_q.push_back(enc_j(21'd2, 5'd1));
		instr_q.push_back(enc_j(21'd8, 5'd15));
		instr_q.push_back(enc_i(12'h009, 5'd0, 3'b000, 5'd16, OPC_JALR));
		instr_q.push_back(enc_i(12'h00A, 5'd0, 3'b000, 5'd16, OPC_JALR));
		instr_q.push_back(enc_i(12'h008, 5'd0, 3'b001, 5'd16, OPC_JALR));
		// unsupported encodings
		instr_q.push_back({25'b0, OPC_FENCE});
		instr_q.push_back(32'h0000_0010);
		instr_q.push_back(32'hFFFF_FFFF);
	endtask

	// input transfers feed the model, output transfers are checked in order
	always @(posedge clk) begin
		result_t exp_r;
		result_t got_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			if (arst_n && in_valid && in_ready) begin
				retire_instr(instr_word, exp_r);
				retire_q.push_back(exp_r);
				in_done = 1'b1;
			end
			if (arst_n && out_valid && out_ready) begin
				got_r.next_pc = next_pc;
				got_r.dest_index = dest_index;
				got_r.dest_value = dest_value;
				got_r.dest_written = dest_written;
				got_r.branch_taken = branch_taken;
				got_r.status = status_t'(status);
				if (retire_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at cycle %0d: %p", cycles, got_r);
				end else begin
					exp_r = retire_q.pop_front();
					if (got_r.next_pc !== exp_r.next_pc ||
							got_r.dest_index !== exp_r.dest_index ||
							got_r.dest_value !== exp_r.dest_value ||
							got_r.dest_written !== exp_r.dest_written ||
							got_r.branch_taken !== exp_r.branch_taken ||
							got_r.status !== exp_r.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch at cycle %0d\n  expected %p\n  actual   %p",
								cycles, exp_r, got_r);
					end
				end
			end
		end
	end

	// driver: present the next instruction once the last one transferred
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_done) begin
				in_done = 1'b0;
				if (instr_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					instr_word <= instr_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// reset, then phases with a new start address each
	initial begin
		logic [31:0] starts [PHASES];
		starts[0] = 32'h0000_0000;
		starts[1] = 32'hFFFF_FFFC;
		starts[2] = 32'h8000_0000;
		starts[3] = {30'($urandom), 2'b00};
		starts[4] = 32'hFFFF_FFFF;
		starts[5] = $urandom;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		instr_word = '0;
		in_done = 1'b0;
		mismatches = 0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		foreach (arch_regs[i]) arch_regs[i] = '0;
		foreach (arch_mem[i]) arch_mem[i] = '0;
		arch_pc = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		// memory clearing pass holds in_ready low
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			send_idle = (p < 2) ? 27 : (p < 4) ? 72 : 0;
			recv_idle = (p < 2) ? 72 : (p < 4) ? 27 : 0;
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= starts[p];
			arch_pc = starts[p];
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			if (p == 0) load_directed();
			for (int n = 0; n < RAND_PER_PHASE; n++) instr_q.push_back(rand_instr());
			while (instr_q.size() > 0 || in_valid || retire_q.size() > 0) @(posedge clk);
			repeat (4) @(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && retire_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: rv32i_execute_unit.f
sv/rvex_pkg.sv
sv/rvex_ram.sv
sv/rvex_exec.sv
sv/rv32i_execute_unit.sv
dv/rv32i_execute_unit_tb.sv
